>>> src/lfps_pkg.sv
package lfps_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEVEL_W     = 8;
  localparam int TICKS_W     = 8;
  localparam int ACC_W       = LEVEL_W + FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ON    = 2'd1,
    CMD_OFF   = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_RAMP = 2'd0,
    KIND_JUMP = 2'd1,
    KIND_LOOP = 2'd2,
    KIND_END  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ON    = 3'd1,
    PH_OFF   = 3'd2,
    PH_FIRST = 3'd3,
    PH_STAY  = 3'd4,
    PH_RUN   = 3'd5,
    PH_NEXT  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_WRITE,
    OP_ON,
    OP_OFF,
    OP_SWITCH,
    OP_STAY,
    OP_RUN,
    OP_READ_FIRST,
    OP_FIRST,
    OP_READ_NEXT,
    OP_ENTER,
    OP_DIV_DONE,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [4:0]         row_index;
    logic [1:0]         row_kind;
    logic [TICKS_W-1:0] row_time;
    logic [LEVEL_W-1:0] row_level;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_level;
    logic               busy_res;
  } out_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [TICKS_W-1:0] ticks;
    logic [LEVEL_W-1:0] level;
  } row_t;

  typedef struct packed {
    cmd_e   cmd;
    phase_e phase;
    logic   need_div;
    logic   div_done;
    logic   out_free;
  } dp_status_t;

endpackage

>>> src/lfps_div.sv
module lfps_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [lfps_pkg::ACC_W-1:0]       dividend_i,
  input  logic [lfps_pkg::TICKS_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [lfps_pkg::ACC_W-1:0]       quotient_o
);

  localparam int CNT_W = $clog2(lfps_pkg::ACC_W + 1);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [lfps_pkg::TICKS_W-1:0]     rem_q, rem_d;
  logic [lfps_pkg::TICKS_W-1:0]     div_q, div_d;
  logic [lfps_pkg::ACC_W-1:0]       quo_q, quo_d;
  logic [lfps_pkg::TICKS_W:0]       trial;
  logic                             fits;

  // Restoring division: the dividend shifts out of the top of quo_q while the
  // quotient bits shift in at the bottom, one bit per cycle.
  assign trial = {rem_q, quo_q[lfps_pkg::ACC_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(lfps_pkg::ACC_W);
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? lfps_pkg::TICKS_W'(trial - {1'b0, div_q})
                   : trial[lfps_pkg::TICKS_W-1:0];
      quo_d = {quo_q[lfps_pkg::ACC_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> src/lfps_dp.sv
module lfps_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lfps_pkg::dp_op_e       op_i,
  input  lfps_pkg::in_word_t     in_word_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output lfps_pkg::out_word_t    out_word_o,
  output lfps_pkg::dp_status_t   status_o
);

  localparam int AW = lfps_pkg::ADDR_W;
  localparam int LW = lfps_pkg::LEVEL_W;
  localparam int FB = lfps_pkg::FRAC_BITS;
  localparam int XW = lfps_pkg::ACC_W;

  lfps_pkg::row_t   mem_q [lfps_pkg::TABLE_DEPTH];
  lfps_pkg::row_t   rd_q;
  lfps_pkg::in_word_t item_q;

  lfps_pkg::phase_e phase_q;
  lfps_pkg::dir_e   dir_q;
  logic [AW-1:0]    ptr_q;
  logic [XW-1:0]    acc_q;
  logic [XW-1:0]    step_q;
  logic [LW-1:0]    target_q;
  logic [lfps_pkg::TICKS_W-1:0] hold_q;
  logic [LW-1:0]    driven_q;
  logic             out_valid_q;
  lfps_pkg::out_word_t out_q;

  logic [AW-1:0]    ptr_inc;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic             wr_en;
  logic [XW-1:0]    tgt_full;
  logic [XW:0]      sum_up;
  logic [XW:0]      tgt_plus;
  logic             run_done;
  logic [XW-1:0]    acc_run;
  logic [LW-1:0]    diff;
  logic [XW-1:0]    diff_full;
  logic             need_div;
  logic             out_free;
  logic             div_done;
  logic [XW-1:0]    quotient;
  lfps_pkg::row_t   wr_row;

  assign ptr_inc = (ptr_q == AW'(lfps_pkg::TABLE_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_inc;
    case (op_i)
      lfps_pkg::OP_READ_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      lfps_pkg::OP_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      lfps_pkg::OP_READ_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = ptr_inc;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = ptr_inc;
      end
    endcase
  end

  assign wr_en = (op_i == lfps_pkg::OP_WRITE) &&
                 (int'(item_q.row_index) < lfps_pkg::TABLE_DEPTH);
  assign wr_row.kind  = lfps_pkg::kind_e'(item_q.row_kind);
  assign wr_row.ticks = item_q.row_time;
  assign wr_row.level = item_q.row_level;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AW'(item_q.row_index)] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
    if (op_i == lfps_pkg::OP_LATCH) begin
      item_q <= in_word_i;
    end
  end

  // One ramp step toward the segment target.
  assign tgt_full = {target_q, {FB{1'b0}}};
  assign sum_up   = {1'b0, acc_q} + {1'b0, step_q};
  assign tgt_plus = {1'b0, tgt_full} + {1'b0, step_q};
  assign run_done = (dir_q == lfps_pkg::DIR_DOWN) ? ({1'b0, acc_q} <= tgt_plus)
                                                  : (sum_up >= {1'b0, tgt_full});
  assign acc_run  = (dir_q == lfps_pkg::DIR_DOWN) ? acc_q - step_q : sum_up[XW-1:0];

  // Segment setup from the row just read; the segment starts at the old target.
  assign diff      = (rd_q.level > target_q) ? rd_q.level - target_q
                                             : target_q - rd_q.level;
  assign diff_full = {diff, {FB{1'b0}}};
  assign need_div  = (rd_q.kind == lfps_pkg::KIND_RAMP) && (rd_q.ticks != '0) &&
                     (rd_q.level != target_q);

  lfps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    ((op_i == lfps_pkg::OP_ENTER) && need_div),
    .dividend_i (diff_full),
    .divisor_i  (rd_q.ticks),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lfps_pkg::PH_IDLE;
      dir_q    <= lfps_pkg::DIR_HOLD;
      ptr_q    <= '0;
      acc_q    <= '0;
      step_q   <= '0;
      target_q <= '0;
      hold_q   <= '0;
      driven_q <= '0;
    end else begin
      case (op_i)
        lfps_pkg::OP_ON: phase_q <= lfps_pkg::PH_ON;
        lfps_pkg::OP_OFF: phase_q <= lfps_pkg::PH_OFF;
        lfps_pkg::OP_SWITCH: begin
          ptr_q    <= '0;
          acc_q    <= '0;
          driven_q <= '0;
          phase_q  <= (phase_q == lfps_pkg::PH_ON) ? lfps_pkg::PH_FIRST
                                                   : lfps_pkg::PH_IDLE;
        end
        lfps_pkg::OP_STAY: begin
          if (hold_q <= 8'd1) begin
            hold_q  <= '0;
            phase_q <= lfps_pkg::PH_NEXT;
          end else begin
            hold_q <= hold_q - 1'b1;
          end
        end
        lfps_pkg::OP_RUN: begin
          if (run_done) begin
            acc_q    <= tgt_full;
            driven_q <= target_q;
            phase_q  <= (hold_q != '0) ? lfps_pkg::PH_STAY : lfps_pkg::PH_NEXT;
          end else begin
            acc_q    <= acc_run;
            driven_q <= acc_run[XW-1:FB];
          end
        end
        lfps_pkg::OP_FIRST: begin
          ptr_q    <= AW'(1);
          driven_q <= rd_q.level;
          target_q <= rd_q.level;
          acc_q    <= {rd_q.level, {FB{1'b0}}};
        end
        lfps_pkg::OP_READ_NEXT: ptr_q <= ptr_inc;
        lfps_pkg::OP_ENTER: begin
          case (rd_q.kind)
            lfps_pkg::KIND_END: phase_q <= lfps_pkg::PH_IDLE;
            lfps_pkg::KIND_LOOP: begin
              ptr_q   <= '0;
              phase_q <= lfps_pkg::PH_FIRST;
            end
            default: begin
              acc_q <= tgt_full;
              if (rd_q.level == target_q) begin
                dir_q   <= lfps_pkg::DIR_HOLD;
                step_q  <= '0;
                hold_q  <= rd_q.ticks;
                phase_q <= lfps_pkg::PH_STAY;
              end else begin
                dir_q    <= (rd_q.level > target_q) ? lfps_pkg::DIR_UP
                                                    : lfps_pkg::DIR_DOWN;
                // Overwritten by the quotient when a division follows.
                step_q   <= diff_full;
                target_q <= rd_q.level;
                if (rd_q.kind == lfps_pkg::KIND_JUMP) begin
                  hold_q <= (rd_q.ticks != '0) ? rd_q.ticks : 8'd1;
                end else begin
                  hold_q <= '0;
                end
                phase_q <= lfps_pkg::PH_RUN;
              end
            end
          endcase
        end
        lfps_pkg::OP_DIV_DONE: step_q <= quotient;
        default: begin
        end
      endcase
    end
  end

  // Output register; the next item can be worked on while a word waits here.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == lfps_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == lfps_pkg::OP_EMIT) begin
      out_q.pwm_level <= driven_q;
      out_q.busy_res  <= (phase_q != lfps_pkg::PH_IDLE);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_word_o        = out_q;
  assign status_o.cmd      = lfps_pkg::cmd_e'(item_q.command);
  assign status_o.phase    = phase_q;
  assign status_o.need_div = need_div;
  assign status_o.div_done = div_done;
  assign status_o.out_free = out_free;

endmodule

>>> src/lfps_ctrl.sv
module lfps_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lfps_pkg::dp_status_t   status_i,
  output lfps_pkg::dp_op_e       op_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_FIRST  = 6'b000100,
    S_ENTER  = 6'b001000,
    S_DIV    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = lfps_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = lfps_pkg::OP_LATCH;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_EMIT;
        case (status_i.cmd)
          lfps_pkg::CMD_WRITE: op_o = lfps_pkg::OP_WRITE;
          lfps_pkg::CMD_ON:    op_o = lfps_pkg::OP_ON;
          lfps_pkg::CMD_OFF:   op_o = lfps_pkg::OP_OFF;
          default: begin
            case (status_i.phase)
              lfps_pkg::PH_ON, lfps_pkg::PH_OFF: op_o = lfps_pkg::OP_SWITCH;
              lfps_pkg::PH_STAY: op_o = lfps_pkg::OP_STAY;
              lfps_pkg::PH_RUN:  op_o = lfps_pkg::OP_RUN;
              lfps_pkg::PH_FIRST: begin
                op_o    = lfps_pkg::OP_READ_FIRST;
                state_d = S_FIRST;
              end
              lfps_pkg::PH_NEXT: begin
                op_o    = lfps_pkg::OP_READ_NEXT;
                state_d = S_ENTER;
              end
              default: op_o = lfps_pkg::OP_NONE;
            endcase
          end
        endcase
      end
      S_FIRST: begin
        op_o    = lfps_pkg::OP_FIRST;
        state_d = S_ENTER;
      end
      S_ENTER: begin
        op_o    = lfps_pkg::OP_ENTER;
        state_d = status_i.need_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          op_o    = lfps_pkg::OP_DIV_DONE;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          op_o    = lfps_pkg::OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> src/led_fade_pattern_sequencer.sv
// Flow: an accepted word is latched, decoded and then emitted to the output register;
// a tick that reads the table also passes the enter state (and the first-row state
// after a switch on), and one that starts a timed ramp waits for the bit-serial step division.
// One word is in work at a time; the output register lets the next word in while a
// result waits. Reset (rst_ni low, asynchronous) leaves the sequencer idle at level 0;
// the pattern table is not cleared and must be loaded before it is played.
module led_fade_pattern_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lfps_pkg::in_word_t    in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lfps_pkg::out_word_t   out_word_o
);

  lfps_pkg::dp_op_e     op;
  lfps_pkg::dp_status_t status;

  lfps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .op_o       (op)
  );

  lfps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .status_o    (status)
  );

endmodule

>>> sim/led_fade_pattern_sequencer_tb.sv
module led_fade_pattern_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 2;
  localparam int RESET_CYCLES    = 11;
  localparam int TOTAL_WORDS     = 850;
  localparam int NUM_DIRECTED    = 25;
  localparam int QUIET_WORDS     = 80;
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 40;
  localparam int IDLE_LIMIT      = 4000;
  localparam int REPORT_LIMIT    = 10;

  localparam int AW = lfps_pkg::ADDR_W;
  localparam int LW = lfps_pkg::LEVEL_W;
  localparam int FB = lfps_pkg::FRAC_BITS;
  localparam int XW = lfps_pkg::ACC_W;
  localparam int TD = lfps_pkg::TABLE_DEPTH;

  typedef struct packed {
    lfps_pkg::cmd_e               cmd;
    logic [4:0]                   idx;
    lfps_pkg::kind_e              kind;
    logic [lfps_pkg::TICKS_W-1:0] ticks;
    logic [LW-1:0]                level;
    logic                         fixed;
    logic [LW-1:0]                exp_level;
    logic                         exp_busy;
  } directed_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  lfps_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  lfps_pkg::out_word_t out_word_o;

  lfps_pkg::out_word_t expected_words [$];
  int                  error_count;
  bit                  quiet;
  bit                  hold_off_req;

  // Mirror of the sequencer state.
  lfps_pkg::row_t   pattern_rows [TD];
  logic [TD-1:0]    row_loaded;
  lfps_pkg::phase_e phase;
  logic [AW-1:0]    row_ptr;
  logic [XW-1:0]    level_acc;
  logic [XW:0]      ramp_step;
  logic [LW-1:0]    seg_target;
  logic [8:0]       hold_count;
  lfps_pkg::dir_e   ramp_dir;
  logic [LW-1:0]    drive_level;

  led_fade_pattern_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [AW-1:0] following_row(input logic [AW-1:0] idx);
    return (idx == AW'(TD - 1)) ? '0 : idx + 1'b1;
  endfunction

  task automatic start_segment(input logic [AW-1:0] idx);
    lfps_pkg::row_t r;
    logic [LW-1:0]  gap;
    logic [XW:0]    scaled;
    r = pattern_rows[idx];
    level_acc = {seg_target, {FB{1'b0}}};
    if (r.level == seg_target) begin
      ramp_dir   = lfps_pkg::DIR_HOLD;
      ramp_step  = '0;
      hold_count = {1'b0, r.ticks};
      phase      = lfps_pkg::PH_STAY;
    end else begin
      if (r.level > seg_target) begin
        ramp_dir = lfps_pkg::DIR_UP;
        gap      = r.level - seg_target;
      end else begin
        ramp_dir = lfps_pkg::DIR_DOWN;
        gap      = seg_target - r.level;
      end
      scaled = {1'b0, gap, {FB{1'b0}}};
      if (r.ticks == '0 || r.kind == lfps_pkg::KIND_JUMP) begin
        ramp_step = scaled;
      end else begin
        ramp_step = scaled / r.ticks;
      end
      seg_target = r.level;
      if (r.kind == lfps_pkg::KIND_JUMP) begin
        hold_count = (r.ticks != '0) ? {1'b0, r.ticks} : 9'd1;
      end else begin
        hold_count = '0;
      end
      phase = lfps_pkg::PH_RUN;
    end
  endtask

  task automatic enter_next_row();
    row_ptr = following_row(row_ptr);
    case (pattern_rows[row_ptr].kind)
      lfps_pkg::KIND_END: begin
        phase = lfps_pkg::PH_IDLE;
      end
      lfps_pkg::KIND_LOOP: begin
        row_ptr = '0;
        phase   = lfps_pkg::PH_FIRST;
      end
      default: begin
        start_segment(row_ptr);
      end
    endcase
  endtask

  task automatic tick_sequencer();
    logic [XW-1:0] goal;
    logic          done;
    case (phase)
      lfps_pkg::PH_ON, lfps_pkg::PH_OFF: begin
        row_ptr     = '0;
        level_acc   = '0;
        drive_level = '0;
        phase       = (phase == lfps_pkg::PH_ON) ? lfps_pkg::PH_FIRST : lfps_pkg::PH_IDLE;
      end
      lfps_pkg::PH_FIRST: begin
        row_ptr     = '0;
        drive_level = pattern_rows[0].level;
        seg_target  = drive_level;
        level_acc   = {drive_level, {FB{1'b0}}};
        enter_next_row();
      end
      lfps_pkg::PH_STAY: begin
        if (hold_count <= 9'd1) begin
          hold_count = '0;
          phase      = lfps_pkg::PH_NEXT;
        end else begin
          hold_count--;
        end
      end
      lfps_pkg::PH_RUN: begin
        goal = {seg_target, {FB{1'b0}}};
        if (ramp_dir == lfps_pkg::DIR_DOWN) begin
          done = level_acc <= goal + ramp_step;
          if (!done) level_acc = level_acc - ramp_step[XW-1:0];
        end else begin
          done = level_acc + ramp_step >= goal;
          if (!done) level_acc = level_acc + ramp_step[XW-1:0];
        end
        if (done) begin
          level_acc   = goal;
          drive_level = seg_target;
          phase       = (hold_count != '0) ? lfps_pkg::PH_STAY : lfps_pkg::PH_NEXT;
        end else begin
          drive_level = level_acc[XW-1 -: LW];
        end
      end
      lfps_pkg::PH_NEXT: begin
        enter_next_row();
      end
      default: ;
    endcase
  endtask

  task automatic apply_word(input lfps_pkg::in_word_t w, output lfps_pkg::out_word_t res);
    case (w.command)
      lfps_pkg::CMD_TICK: tick_sequencer();
      lfps_pkg::CMD_ON:   phase = lfps_pkg::PH_ON;
      lfps_pkg::CMD_OFF:  phase = lfps_pkg::PH_OFF;
      default: begin
        if (w.row_index < TD) begin
          pattern_rows[w.row_index].kind  = lfps_pkg::kind_e'(w.row_kind);
          pattern_rows[w.row_index].ticks = w.row_time;
          pattern_rows[w.row_index].level = w.row_level;
          row_loaded[w.row_index]         = 1'b1;
        end
      end
    endcase
    res.pwm_level = drive_level;
    res.busy_res  = (phase != lfps_pkg::PH_IDLE);
  endtask

  // Row that the next tick would read although it was never loaded, or -1.
  function automatic int unloaded_row_ahead();
    case (phase)
      lfps_pkg::PH_FIRST: begin
        if (!row_loaded[0]) return 0;
        if (!row_loaded[following_row('0)]) return int'(following_row('0));
      end
      lfps_pkg::PH_NEXT: begin
        if (!row_loaded[following_row(row_ptr)]) return int'(following_row(row_ptr));
      end
      default: ;
    endcase
    return -1;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input lfps_pkg::in_word_t w, input logic fixed,
                           input lfps_pkg::out_word_t fixed_res);
    lfps_pkg::out_word_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    apply_word(w, predicted);
    expected_words.push_back(fixed ? fixed_res : predicted);
    @(negedge clk_i);
  endtask

  initial begin
    directed_row_t       directed [NUM_DIRECTED];
    lfps_pkg::in_word_t  w;
    lfps_pkg::in_word_t  plan_q [$];
    lfps_pkg::out_word_t fixed_res;
    logic [LW-1:0]       prev;
    int                  random_words;
    int                  body;
    int                  pick;
    int                  ahead;
    bit                  hold_off_sent;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    phase       = lfps_pkg::PH_IDLE;
    row_ptr     = '0;
    level_acc   = '0;
    ramp_step   = '0;
    seg_target  = '0;
    hold_count  = '0;
    ramp_dir    = lfps_pkg::DIR_HOLD;
    drive_level = '0;
    row_loaded  = '0;

    // Row 0 carries an end kind that must be ignored; row 1 jumps down with time 0,
    // row 2 ramps with a truncated step, row 3 holds an equal level for zero
    // ticks, row 4 ramps up with time 0 and row 5 loops back.
    directed = '{
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b1, 8'd0,   1'b0},
      '{lfps_pkg::CMD_WRITE, 5'd0, lfps_pkg::KIND_END,  8'd255, 8'd255, 1'b1, 8'd0,   1'b0},
      '{lfps_pkg::CMD_WRITE, 5'd1, lfps_pkg::KIND_JUMP, 8'd0,   8'd0,   1'b1, 8'd0,   1'b0},
      '{lfps_pkg::CMD_WRITE, 5'd2, lfps_pkg::KIND_RAMP, 8'd3,   8'd100, 1'b1, 8'd0,   1'b0},
      '{lfps_pkg::CMD_WRITE, 5'd3, lfps_pkg::KIND_RAMP, 8'd0,   8'd100, 1'b1, 8'd0,   1'b0},
      '{lfps_pkg::CMD_WRITE, 5'd4, lfps_pkg::KIND_RAMP, 8'd0,   8'd255, 1'b1, 8'd0,   1'b0},
      '{lfps_pkg::CMD_WRITE, 5'd5, lfps_pkg::KIND_LOOP, 8'd0,   8'd0,   1'b1, 8'd0,   1'b0},
      '{lfps_pkg::CMD_ON,    5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b1, 8'd0,   1'b1},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b1, 8'd0,   1'b1},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b1, 8'd255, 1'b1},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
      '{lfps_pkg::CMD_OFF,   5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b1, 8'd255, 1'b1},
      '{lfps_pkg::CMD_TICK,  5'd0, lfps_pkg::KIND_RAMP, 8'd0,   8'd0,   1'b1, 8'd0,   1'b0}
    };

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[k]) begin
      w                   = '0;
      w.command           = directed[k].cmd;
      w.row_index         = directed[k].idx;
      w.row_kind          = directed[k].kind;
      w.row_time          = directed[k].ticks;
      w.row_level         = directed[k].level;
      fixed_res.pwm_level = directed[k].exp_level;
      fixed_res.busy_res  = directed[k].exp_busy;
      send_word(w, directed[k].fixed, fixed_res);
    end

    random_words  = 0;
    hold_off_sent = 1'b0;
    while (random_words < TOTAL_WORDS - NUM_DIRECTED) begin
      if (plan_q.size() == 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          // Load a pattern from row 0 and play it. A long body without a
          // terminator makes the row pointer wrap.
          body = ($urandom_range(0, 11) == 0) ? $urandom_range(8, TD - 1)
                                              : $urandom_range(1, 6);
          prev = 8'($urandom);
          for (int i = 0; i <= body; i++) begin
            w           = lfps_pkg::in_word_t'($urandom);
            w.command   = lfps_pkg::CMD_WRITE;
            w.row_index = 5'(i);
            w.row_kind  = ($urandom_range(0, 2) == 0) ? lfps_pkg::KIND_JUMP
                                                      : lfps_pkg::KIND_RAMP;
            w.row_time  = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 5));
            case ($urandom_range(0, 7))
              0:       w.row_level = prev;
              1:       w.row_level = '0;
              2:       w.row_level = '1;
              default: w.row_level = 8'($urandom);
            endcase
            prev = w.row_level;
            plan_q.push_back(w);
          end
          if (body < TD - 1) begin
            w           = lfps_pkg::in_word_t'($urandom);
            w.command   = lfps_pkg::CMD_WRITE;
            w.row_index = 5'(body + 1);
            w.row_kind  = $urandom_range(0, 1) ? lfps_pkg::KIND_LOOP : lfps_pkg::KIND_END;
            plan_q.push_back(w);
          end
          w         = lfps_pkg::in_word_t'($urandom);
          w.command = lfps_pkg::CMD_ON;
          plan_q.push_back(w);
          repeat ($urandom_range(10, 80)) begin
            w         = lfps_pkg::in_word_t'($urandom);
            w.command = lfps_pkg::CMD_TICK;
            plan_q.push_back(w);
          end
        end else if (pick < 16) begin
          repeat ($urandom_range(5, 40)) begin
            w         = lfps_pkg::in_word_t'($urandom);
            w.command = lfps_pkg::CMD_TICK;
            plan_q.push_back(w);
          end
        end else begin
          repeat ($urandom_range(1, 4)) plan_q.push_back(lfps_pkg::in_word_t'($urandom));
        end
      end

      // A tick that would read a row never loaded is preceded by a write of it.
      ahead = (plan_q[0].command == lfps_pkg::CMD_TICK) ? unloaded_row_ahead() : -1;
      if (ahead >= 0) begin
        w           = lfps_pkg::in_word_t'($urandom);
        w.command   = lfps_pkg::CMD_WRITE;
        w.row_index = 5'(ahead);
      end else begin
        w = plan_q.pop_front();
      end
      random_words++;
      if (random_words >= TOTAL_WORDS - NUM_DIRECTED - QUIET_WORDS) quiet = 1'b1;
      if (random_words >= HOLD_OFF_AT && !hold_off_sent) begin
        hold_off_sent = 1'b1;
        hold_off_req  = 1'b1;
      end
      send_word(w, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count + expected_words.size() == 0) begin
      $display("led_fade_pattern_sequencer_tb: clean");
    end else begin
      $display("led_fade_pattern_sequencer_tb: errors");
    end
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off that backs the block up.
  initial begin
    bit held_off;
    held_off    = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    lfps_pkg::out_word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_error($sformatf("word with nothing expected: level %0d busy %0b",
                                 out_word_o.pwm_level, out_word_o.busy_res));
        end else begin
          want = expected_words.pop_front();
          if (out_word_o.pwm_level !== want.pwm_level ||
              out_word_o.busy_res !== want.busy_res) begin
            report_error($sformatf("got level %0d busy %0b, expected level %0d busy %0b",
                                   out_word_o.pwm_level, out_word_o.busy_res,
                                   want.pwm_level, want.busy_res));
          end
        end
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    wait (rst_ni === 1'b1);
    while (stuck < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("led_fade_pattern_sequencer_tb: errors");
    $finish;
  end

endmodule

>>> filelist.f
src/lfps_pkg.sv
src/lfps_div.sv
src/lfps_dp.sv
src/lfps_ctrl.sv
src/led_fade_pattern_sequencer.sv
sim/led_fade_pattern_sequencer_tb.sv
